// File: hdl/mfwp_pkg.sv
// Package for the widest-path max-flow block: sizes, constants, command/status types.
// No dependencies.
package mfwp_pkg;
  localparam int NodeCount = 64;
  localparam int NodeW     = $clog2(NodeCount);
  localparam int MatW      = 2 * NodeW;
  localparam int ResW      = 16;
  localparam int BotW      = 11;
  localparam int CfgW      = 6;
  localparam logic [ResW-1:0] Max16 = 16'hFFFF;
  localparam logic [BotW-1:0] SeedWidth = 11'd1024;

  localparam logic [0:0] CfgSource = 1'b0;
  localparam logic [0:0] CfgSink   = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_CLEAR  = 4'd2,  // clear search arrays, seed source
    OP_SCAN   = 4'd3,  // one node of the pick scan
    OP_RELAX  = 4'd4,  // one edge of the relax sweep
    OP_AUGF   = 4'd5,  // augment: read forward/reverse
    OP_AUGW   = 4'd6,  // augment: write back
    OP_WIPE   = 4'd7   // reset clearing pass, one entry
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [NodeW-1:0] idx;
    logic             first;   // first element of a sweep
    logic             visit;   // mark picked node visited
  } dp_cmd_t;

  typedef struct packed {
    logic             found;      // scan result valid
    logic [NodeW-1:0] pick;
    logic [BotW-1:0]  best;
    logic [NodeW-1:0] cur;        // augment walk position
  } dp_sts_t;
endpackage

// File: hdl/max_flow_widest_path_top.sv
// Run item, per round: a clear pass, then scan, decide and relax for each node taken before
// the sink, a last scan and decide, and an augment walk along the path once it is reached.
// Rounds repeat until a scan finds no node; then the done state makes the result valid.
// Source equal to sink: straight to done. Load item: written when taken. One item at a time:
// the next transfer waits for the result to leave. Reset (synchronous, rst_n low) then runs
// a wipe pass over every residual memory entry; no input is taken until it ends.
module max_flow_widest_path_top import mfwp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [CfgW-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_kind,
  input  logic [5:0]      in_from_node,
  input  logic [5:0]      in_to_node,
  input  logic [7:0]      in_edge_capacity,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     out_flow_value,
  output logic            out_is_infinite
);
  logic [NodeW-1:0] src_r, snk_r;
  dp_cmd_t cmd;
  dp_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= '0; snk_r <= NodeW'(NodeCount - 1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgSource: src_r <= cfg_data;
        CfgSink:   snk_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mfwp_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind,
    .src(src_r), .snk(snk_r),
    .out_valid, .out_ready, .out_flow_value, .out_is_infinite,
    .cmd, .sts
  );

  mfwp_datapath u_dp (
    .clk, .cmd, .src(src_r), .snk(snk_r),
    .ld_from(in_from_node), .ld_to(in_to_node), .ld_cap(in_edge_capacity), .sts
  );
endmodule

// File: hdl/mfwp_datapath.sv
// Datapath: residual memory, per-node search arrays, scan and augment registers.
// Depends on mfwp_pkg.
module mfwp_datapath import mfwp_pkg::*; (
  input  logic             clk,
  input  dp_cmd_t          cmd,
  input  logic [NodeW-1:0] src,
  input  logic [NodeW-1:0] snk,
  input  logic [NodeW-1:0] ld_from,
  input  logic [NodeW-1:0] ld_to,
  input  logic [7:0]       ld_cap,
  output dp_sts_t          sts
);
  logic [ResW-1:0]  mem [NodeCount*NodeCount];
  logic [BotW-1:0]  bot_r [NodeCount];
  logic             vis_r [NodeCount];
  logic [NodeW-1:0] pred_r [NodeCount];

  logic             found_r;
  logic [NodeW-1:0] pick_r, cur_r, prev_r;
  logic [BotW-1:0]  best_r;
  logic [ResW-1:0]  rd_r;
  logic [MatW-1:0]  rd_addr, wr_addr;
  logic [ResW-1:0]  wr_data;
  logic             wr_en;
  logic [ResW-1:0]  amt_r;
  logic [ResW:0]    rev_sum;
  logic [ResW-1:0]  fwd_new;
  logic [BotW-1:0]  relax_w;
  logic [NodeW-1:0] relax_i_r;
  logic             relax_v_r;
  logic             scan_v_r, scan_f_r;
  logic [BotW-1:0]  bot_rd_r, scan_thr;
  logic             vis_rd_r, scan_hit;
  logic [NodeW-1:0] pred_rd_r, pred_addr;

  // Memory read address: relax row pick, augment reads forward then reverse.
  always_comb begin
    rd_addr = {pick_r, cmd.idx};
    if (cmd.op == OP_AUGF) begin
      rd_addr = cmd.first ? {pred_rd_r, cur_r} : {cur_r, pred_rd_r};
    end
  end

  // Predecessor read follows the walk: on the step back, fetch for the next node.
  assign pred_addr = (cmd.op == OP_AUGW && !cmd.first) ? prev_r : cur_r;

  assign rev_sum = {1'b0, rd_r} + {1'b0, amt_r};
  assign fwd_new = (rd_r >= amt_r) ? rd_r - amt_r : '0;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {ld_from, ld_to};
    wr_data = {8'd0, ld_cap};
    unique case (cmd.op)
      OP_LOAD: wr_en = 1'b1;
      OP_WIPE: begin
        wr_en   = 1'b1;
        wr_addr = {cur_r, cmd.idx};
        wr_data = '0;
      end
      OP_AUGW: begin
        wr_en = 1'b1;
        if (cmd.first) begin
          wr_addr = {prev_r, cur_r};
          wr_data = fwd_new;
        end else begin
          wr_addr = {cur_r, prev_r};
          wr_data = rev_sum[ResW] ? Max16 : rev_sum[ResW-1:0];
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    bot_rd_r  <= bot_r[cmd.idx];
    vis_rd_r  <= vis_r[cmd.idx];
    pred_rd_r <= pred_r[pred_addr];
  end

  // Scan and relax both see registered reads: element relax_i_r is handled in the cycle after its command.
  assign relax_w  = (rd_r < {5'd0, best_r}) ? rd_r[BotW-1:0] : best_r;
  assign scan_thr = scan_f_r ? '0 : best_r;
  assign scan_hit = scan_v_r && !vis_rd_r && (bot_rd_r > scan_thr);

  always_ff @(posedge clk) begin
    relax_v_r <= (cmd.op == OP_RELAX);
    scan_v_r  <= (cmd.op == OP_SCAN);
    scan_f_r  <= cmd.first;
    relax_i_r <= cmd.idx;
    if (relax_v_r && rd_r != '0 && bot_rd_r < relax_w) begin
      bot_r[relax_i_r]  <= relax_w;
      pred_r[relax_i_r] <= pick_r;
    end
    if (scan_hit) begin
      best_r  <= bot_rd_r;
      pick_r  <= relax_i_r;
      found_r <= 1'b1;
    end else if (scan_v_r && scan_f_r) begin
      found_r <= 1'b0;
      best_r  <= '0;
    end
    unique case (cmd.op)
      OP_CLEAR: begin
        bot_r[cmd.idx]  <= (cmd.idx == src) ? SeedWidth : '0;
        vis_r[cmd.idx]  <= 1'b0;
        pred_r[cmd.idx] <= '0;
        cur_r           <= snk;
      end
      OP_RELAX: if (cmd.visit) vis_r[pick_r] <= 1'b1;
      OP_AUGF: begin
        // best_r still holds the sink's bottleneck
        if (cmd.first) amt_r <= {5'd0, best_r};
        prev_r <= pred_rd_r;
      end
      OP_AUGW: if (!cmd.first) cur_r <= prev_r;
      OP_WIPE: if (cmd.first) cur_r <= cur_r + 1'b1;
      default: ;
    endcase
    if (cmd.op == OP_NONE && cmd.first) cur_r <= '0;
  end

  assign sts.found = found_r;
  assign sts.pick  = pick_r;
  assign sts.best  = best_r;
  assign sts.cur   = cur_r;
endmodule

// File: hdl/mfwp_ctrl.sv
// Controller state machine sequencing load, search, augment and reset wipe.
// Depends on mfwp_pkg.
module mfwp_ctrl import mfwp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [NodeW-1:0] src,
  input  logic [NodeW-1:0] snk,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ResW-1:0]  out_flow_value,
  output logic             out_is_infinite,
  output dp_cmd_t          cmd,
  input  dp_sts_t          sts
);
  typedef enum logic [8:0] {
    S_WIPE  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CLR   = 9'b000000100,
    S_SCAN  = 9'b000001000,
    S_DEC   = 9'b000010000,
    S_RELAX = 9'b000100000,
    S_AUGF  = 9'b001000000,
    S_AUGW  = 9'b010000000,
    S_DONE  = 9'b100000000
  } st_t;

  st_t st_r, st_nxt;
  logic [NodeW:0]   cnt_r, cnt_nxt;
  logic [NodeW:0]   steps_r, steps_nxt;
  logic             ph_r, ph_nxt;
  logic [ResW-1:0]  tot_r, tot_nxt;
  logic             inf_r, inf_nxt;
  logic             ov_r, ov_nxt;
  logic [ResW:0]    tot_sum;
  logic             last;
  logic             take;

  assign last = (cnt_r == (NodeW+1)'(NodeCount - 1));
  assign take = in_valid && in_ready;
  assign in_ready = (st_r == S_IDLE) && !ov_r;
  assign tot_sum = {1'b0, tot_r} + {6'd0, sts.best};

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; ph_nxt = ph_r; steps_nxt = steps_r;
    tot_nxt = tot_r; inf_nxt = inf_r; ov_nxt = ov_r;
    cmd = '{op: OP_NONE, idx: cnt_r[NodeW-1:0], first: 1'b0, visit: 1'b0};
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      S_WIPE: begin
        cmd.op = OP_WIPE; cmd.first = last;
        cnt_nxt = last ? '0 : cnt_r + 1'b1;
        if (last && sts.cur == NodeW'(NodeCount - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (take) begin
          if (!in_kind) cmd.op = OP_LOAD;
          else if (src == snk) begin
            tot_nxt = Max16; inf_nxt = 1'b1; st_nxt = S_DONE;
          end else begin
            tot_nxt = '0; inf_nxt = 1'b0; cnt_nxt = '0; st_nxt = S_CLR;
          end
        end
      end
      S_CLR: begin
        cmd.op = OP_CLEAR;
        cnt_nxt = last ? '0 : cnt_r + 1'b1;
        if (last) st_nxt = S_SCAN;
      end
      S_SCAN: begin
        // a final OP_NONE step drains the registered read
        cmd.op = (cnt_r == (NodeW+1)'(NodeCount)) ? OP_NONE : OP_SCAN;
        cmd.first = (cnt_r == '0);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (NodeW+1)'(NodeCount)) begin
          cnt_nxt = '0; st_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts.found) st_nxt = S_DONE;
        else if (sts.pick == snk) begin
          tot_nxt = tot_sum[ResW] ? Max16 : tot_sum[ResW-1:0];
          steps_nxt = '0; ph_nxt = 1'b1; st_nxt = S_AUGF;
        end else begin
          cnt_nxt = '0; st_nxt = S_RELAX;
        end
      end
      S_RELAX: begin
        // a final OP_NONE step drains the registered read
        cmd.op = (cnt_r == (NodeW+1)'(NodeCount)) ? OP_NONE : OP_RELAX;
        cmd.visit = (cnt_r == '0);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (NodeW+1)'(NodeCount)) begin
          cnt_nxt = '0; st_nxt = S_SCAN;
        end
      end
      S_AUGF: begin
        if (sts.cur == src || steps_r == (NodeW+1)'(NodeCount)) begin
          cnt_nxt = '0; st_nxt = S_CLR;
        end else begin
          cmd.op = OP_AUGF; cmd.first = ph_r; st_nxt = S_AUGW;
        end
      end
      S_AUGW: begin
        cmd.op = OP_AUGW; cmd.first = ph_r;
        ph_nxt = !ph_r;
        if (!ph_r) steps_nxt = steps_r + 1'b1;
        st_nxt = S_AUGF;
      end
      S_DONE: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    // in reset: no memory writes, wipe row pointer homed
    if (!rst_n) begin
      cmd.op = OP_NONE; cmd.first = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_WIPE; cnt_r <= '0; ov_r <= 1'b0; ph_r <= 1'b0; steps_r <= '0;
      tot_r <= '0; inf_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt; ph_r <= ph_nxt;
      steps_r <= steps_nxt; tot_r <= tot_nxt; inf_r <= inf_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_flow_value = tot_r;
  assign out_is_infinite = inf_r;

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> st_r == S_IDLE) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_flow_value))
    else $error("result dropped");
  a_inf_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_infinite |-> out_flow_value == Max16)
    else $error("infinite flag with finite total");
`endif
endmodule
